// ===== rtl/core/bba_pkg.sv =====
// Package for the block bitmap allocator: request codes, geometry constants,
// controller state type, command and status structs, and priority encoders.
// Depends on nothing; every other file of the block uses it.
package bba_pkg;

   // Pool size in blocks; only blocks below 65536 can be addressed.
   localparam int NUM_BLOCKS = 65536;
   localparam int ADDR_SPAN  = 65536;
   localparam int SCAN_LIMIT = (NUM_BLOCKS < ADDR_SPAN) ? NUM_BLOCKS : ADDR_SPAN;

   // Field widths.
   localparam int REQ_W = 2;
   localparam int BLK_W = 16;

   // Bitmap geometry: 64-bit words, grouped 32 words per summary row.
   localparam int WORD_W    = 64;
   localparam int OFF_W     = 6;
   localparam int NUM_WORDS = ADDR_SPAN / WORD_W;
   localparam int ADDR_W    = BLK_W - OFF_W;
   localparam int ROW_W     = 32;
   localparam int ROW_IDX_W = 5;
   localparam int NUM_ROWS  = NUM_WORDS / ROW_W;
   localparam int GRP_IDX_W = ADDR_W - ROW_IDX_W;

   // Wide constants for range checks.
   localparam logic [20:0] NUM_BLOCKS_W = 21'(NUM_BLOCKS);
   localparam logic [16:0] SCAN_LIMIT_W = 17'(SCAN_LIMIT);

   // Request codes; the fourth code is unused and only echoes.
   localparam logic [REQ_W-1:0] REQ_FIND    = 2'd0;
   localparam logic [REQ_W-1:0] REQ_MARK    = 2'd1;
   localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;

   // Result status codes.
   localparam logic STS_OK      = 1'b0;
   localparam logic STS_NO_FREE = 1'b1;

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_EXEC,
      ST_RESULT
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic capture;
      logic clear_step;
      logic set_addr;
      logic set_echo;
      logic set_none;
      logic exec;
      logic load_out;
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic clear_last;
      logic is_find;
      logic is_update;
      logic any_free;
      logic out_free;
   } sts_type;

   // Index of the lowest set bit of an 8-bit value, zero if none.
   function automatic logic [2:0] first_set8(input logic [7:0] v);
      logic [2:0] idx;
      idx = '0;
      for (int k = 7; k >= 0; k--) begin
         if (v[k]) begin
            idx = 3'(k);
         end
      end
      return idx;
   endfunction

   // Index of the lowest set bit of a 32-bit value, byte first then bit.
   function automatic logic [4:0] first_set32(input logic [31:0] v);
      logic [7:0] any;
      logic [2:0] b;
      any = '0;
      for (int i = 0; i < 4; i++) begin
         any[i] = |v[8*i +: 8];
      end
      b = first_set8(any);
      return {b[1:0], first_set8(v[8*b[1:0] +: 8])};
   endfunction

   // Index of the lowest set bit of a 64-bit value, byte first then bit.
   function automatic logic [5:0] first_set64(input logic [63:0] v);
      logic [7:0] any;
      logic [2:0] b;
      any = '0;
      for (int i = 0; i < 8; i++) begin
         any[i] = |v[8*i +: 8];
      end
      b = first_set8(any);
      return {b, first_set8(v[8*b +: 8])};
   endfunction

endpackage

// ===== rtl/core/bba_if.sv =====
// Handshake channels of the block bitmap allocator: request and response.
// Depends on bba_pkg for the payload widths.
interface bba_req_if;
   logic                        valid;
   logic                        ready;
   logic [bba_pkg::REQ_W-1:0]   req_type;
   logic [bba_pkg::BLK_W-1:0]   block_number;

   modport source (output valid, output req_type, output block_number, input ready);
   modport sink   (input valid, input req_type, input block_number, output ready);
endinterface

interface bba_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bba_pkg::BLK_W-1:0]   found_block;
   logic                        status;

   modport source (output valid, output found_block, output status, input ready);
   modport sink   (input valid, input found_block, input status, output ready);
endinterface

// ===== rtl/core/bba_ctrl.sv =====
// Controller state machine of the block bitmap allocator.
// Depends on bba_pkg; drives commands to bba_datapath and reads its status.
module bba_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bba_pkg::sts_type sts,
   output bba_pkg::cmd_type cmd
);
   import bba_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register; reset starts the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            priority if (sts.is_find && !sts.any_free) begin
               cmd.set_none = 1'b1;
               state_in     = ST_RESULT;
            end else if (sts.is_find || sts.is_update) begin
               cmd.set_addr = 1'b1;
               state_in     = ST_READ;
            end else begin
               cmd.set_echo = 1'b1;
               state_in     = ST_RESULT;
            end
         end
         ST_READ: begin
            // The word read is registered; it is available next cycle.
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

// ===== rtl/core/bba_datapath.sv =====
// Datapath of the block bitmap allocator: bitmap memory, full-word summary,
// request and result registers, and the output register.
// Depends on bba_pkg; commanded by bba_ctrl.
module bba_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  bba_pkg::cmd_type          cmd,
   output bba_pkg::sts_type          sts,
   input  logic [bba_pkg::REQ_W-1:0] req_type,
   input  logic [bba_pkg::BLK_W-1:0] block_number,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [bba_pkg::BLK_W-1:0] found_block,
   output logic                      status
);
   import bba_pkg::*;

   // Bitmap memory: bit k of word w is block w*64+k, set means used.
   logic [WORD_W-1:0] map_mem [NUM_WORDS];

   logic [REQ_W-1:0]  type_ff,    type_in;
   logic [BLK_W-1:0]  blk_ff,     blk_in;
   logic [ADDR_W-1:0] addr_ff,    addr_in;
   logic [WORD_W-1:0] rd_data_ff;
   logic [BLK_W-1:0]  res_blk_ff, res_blk_in;
   logic              res_sts_ff, res_sts_in;
   logic [BLK_W-1:0]  out_blk_ff, out_blk_in;
   logic              out_sts_ff, out_sts_in;
   logic              out_vld_ff, out_vld_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [ROW_W-1:0]  full_ff [NUM_ROWS];
   logic [ROW_W-1:0]  full_in [NUM_ROWS];

   logic                 is_find;
   logic                 is_mark;
   logic                 is_update;
   logic [NUM_ROWS-1:0]  row_open;
   logic [GRP_IDX_W-1:0] grp_sel;
   logic [ADDR_W-1:0]    word_sel;
   logic [WORD_W-1:0]    bit_mask;
   logic [WORD_W-1:0]    new_word;
   logic [BLK_W-1:0]     find_blk;
   logic                 find_ok;

   // Request decode and range check.
   always_comb begin
      is_find   = (type_ff == REQ_FIND);
      is_mark   = (type_ff == REQ_MARK);
      is_update = (is_mark || type_ff == REQ_RELEASE) && ({5'b0, blk_ff} < NUM_BLOCKS_W);
   end

   // Summary search: first row with a non-full word, then that word.
   always_comb begin
      for (int g = 0; g < NUM_ROWS; g++) begin
         row_open[g] = ~&full_ff[g];
      end
      grp_sel  = first_set32(row_open);
      word_sel = {grp_sel, first_set32(~full_ff[grp_sel])};
   end

   // Word update for mark and release, and the free-bit search for find.
   always_comb begin
      bit_mask = WORD_W'(1) << blk_ff[OFF_W-1:0];
      new_word = is_mark ? (rd_data_ff | bit_mask) : (rd_data_ff & ~bit_mask);
      find_blk = {addr_ff, first_set64(~rd_data_ff)};
      find_ok  = ({1'b0, find_blk} < SCAN_LIMIT_W);
   end

   // Next values of the registers.
   always_comb begin
      type_in    = type_ff;
      blk_in     = blk_ff;
      addr_in    = addr_ff;
      res_blk_in = res_blk_ff;
      res_sts_in = res_sts_ff;
      out_blk_in = out_blk_ff;
      out_sts_in = out_sts_ff;
      out_vld_in = out_vld_ff && !rsp_ready;
      clr_cnt_in = clr_cnt_ff;
      full_in    = full_ff;

      if (cmd.capture) begin
         type_in = req_type;
         blk_in  = block_number;
      end
      if (cmd.clear_step) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
      end
      if (cmd.set_addr) begin
         addr_in = is_find ? word_sel : blk_ff[BLK_W-1:OFF_W];
      end
      if (cmd.set_echo) begin
         res_blk_in = blk_ff;
         res_sts_in = STS_OK;
      end
      if (cmd.set_none) begin
         res_blk_in = '0;
         res_sts_in = STS_NO_FREE;
      end
      if (cmd.exec) begin
         if (is_find) begin
            res_blk_in = find_ok ? find_blk : '0;
            res_sts_in = find_ok ? STS_OK : STS_NO_FREE;
         end else begin
            res_blk_in = blk_ff;
            res_sts_in = STS_OK;
         end
         if (is_update) begin
            full_in[addr_ff[ADDR_W-1:ROW_IDX_W]][addr_ff[ROW_IDX_W-1:0]] = &new_word;
         end
      end
      if (cmd.load_out) begin
         out_vld_in = 1'b1;
         out_blk_in = res_blk_ff;
         out_sts_in = res_sts_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         clr_cnt_ff <= '0;
         for (int g = 0; g < NUM_ROWS; g++) begin
            full_ff[g] <= '0;
         end
      end else begin
         out_vld_ff <= out_vld_in;
         clr_cnt_ff <= clr_cnt_in;
         full_ff    <= full_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      type_ff    <= type_in;
      blk_ff     <= blk_in;
      addr_ff    <= addr_in;
      res_blk_ff <= res_blk_in;
      res_sts_ff <= res_sts_in;
      out_blk_ff <= out_blk_in;
      out_sts_ff <= out_sts_in;
   end

   // Bitmap memory: one write port (clearing pass or update), one read port.
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         map_mem[clr_cnt_ff] <= '0;
      end else if (cmd.exec && is_update) begin
         map_mem[addr_ff] <= new_word;
      end
      rd_data_ff <= map_mem[addr_ff];
   end

   // Status toward the controller and the response outputs.
   always_comb begin
      sts.clear_last = (clr_cnt_ff == ADDR_W'(NUM_WORDS - 1));
      sts.is_find    = is_find;
      sts.is_update  = is_update;
      sts.any_free   = |row_open;
      sts.out_free   = !out_vld_ff || rsp_ready;
      rsp_valid      = out_vld_ff;
      found_block    = out_blk_ff;
      status         = out_sts_ff;
   end

endmodule

// ===== rtl/core/block_bitmap_allocator.sv =====
// Block bitmap allocator, first fit, over a 65536-block pool.
// A find, mark or release goes through decode and summary search, registered bitmap read,
// execute and the output register; a find with no free block, an unused code or an
// out-of-range block skips read and execute. The result waits for a free output register.
// One request at a time: the next is accepted only after the last has been moved to the
// output register. Reset clears the summary at once, then a pass zeroes the bitmap memory
// one word a cycle; no request is accepted until it ends.
module block_bitmap_allocator (
   input logic       clock,
   input logic       reset,
   bba_req_if.sink   req_chan,
   bba_rsp_if.source rsp_chan
);
   import bba_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencing of each request.
   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Bitmap storage, search and result registers.
   bba_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_type     (req_chan.req_type),
      .block_number (req_chan.block_number),
      .rsp_ready    (rsp_chan.ready),
      .rsp_valid    (rsp_chan.valid),
      .found_block  (rsp_chan.found_block),
      .status       (rsp_chan.status)
   );

   // A request is processed alone: ready drops right after acceptance.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while a previous one is in progress");

   // A failed find always reports block zero.
   a_no_free_block_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == STS_NO_FREE) |-> (rsp_chan.found_block == '0))
      else $error("no-free response carries a nonzero block");

   // No request is taken while the bitmap clearing pass runs.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.clear_step) |-> !req_chan.ready)
      else $error("request ready during bitmap clearing");

endmodule
